// ----- sv/bdn_pkg.sv -----
// ----------------------------------------------------------------------------
// bdn_pkg
// Shared types, constants and arithmetic helpers for the RAW10 Bayer
// demosaic to NV12 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bdn_pkg;

  // Line store geometry
  localparam int LINE_W      = 4096;
  localparam int LINE_AW     = $clog2(LINE_W);
  localparam int NUM_SLOTS   = 3;

  // Decoupling queue between front and back
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = Q_AW + 1;

  // Phase of the last byte in a five-byte packed group, which carries the LSBs
  localparam logic [2:0] GROUP_LSB_PHASE = 3'd4;

  // BT.601 coefficients, 8-bit fixed point
  localparam logic [16:0] Y_R  = 17'd77;
  localparam logic [16:0] Y_G  = 17'd150;
  localparam logic [16:0] Y_B  = 17'd29;
  localparam logic [17:0] CB_R = 18'd43;
  localparam logic [17:0] CB_G = 18'd85;
  localparam logic [17:0] CR_G = 18'd107;
  localparam logic [17:0] CR_B = 18'd21;
  localparam logic [17:0] C_HALF = 18'd128;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROW_STRIDE = 3'd0,
    CFG_CROP_LEFT  = 3'd1,
    CFG_CROP_TOP   = 3'd2,
    CFG_OUT_WIDTH  = 3'd3,
    CFG_OUT_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [12:0] row_stride_bytes;
    logic [11:0] crop_left;
    logic [11:0] crop_top;
    logic [11:0] out_width;
    logic [11:0] out_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [10:0] tile_col;
    logic [10:0] tile_row;
    logic [7:0]  luma_top_left;
    logic [7:0]  luma_top_right;
    logic [7:0]  luma_bottom_left;
    logic [7:0]  luma_bottom_right;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic        frame_done;
  } out_t;

  // Neighborhood of one tile, as queued from front to back
  typedef struct packed {
    logic [7:0]  em;
    logic [7:0]  e0;
    logic [7:0]  e1;
    logic [7:0]  e2;
    logic [7:0]  pm;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [7:0]  m2;
    logic [7:0]  qm;
    logic [7:0]  q0;
    logic [7:0]  q1;
    logic [10:0] tile_col;
    logic [10:0] tile_row;
    logic        frame_done;
  } tile_t;

  // Round-half-up average of two
  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  // Round-half-up average of four
  function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [9:0] s;
    s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d} + 10'd2;
    return s[9:2];
  endfunction

  // BT.601 luma; the sum never exceeds 16 bits
  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [16:0] s;
    s = Y_R * {9'd0, r} + Y_G * {9'd0, g} + Y_B * {9'd0, b} + 17'd128;
    return s[15:8];
  endfunction

  // Floor shift by 8, add the chroma offset and clip to 0..255
  function automatic logic [7:0] chroma_clip(input logic [17:0] v);
    logic signed [17:0] t;
    t = ($signed(v) >>> 8) + $signed(C_HALF);
    if (t < 0) begin
      return 8'd0;
    end else if (t > 18'sd255) begin
      return 8'd255;
    end
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/bayer_raw10_demosaic_to_nv12_unit.sv -----
// Throughput: one packed byte per clock, sustained, while results are taken.
// Path: a tile's trigger byte passes through the window stage, queue,
//   interpolation and output register once accepted.
// A four-entry queue parts front and back; the input stalls when the queue
//   level plus a byte in the window stage reaches four.
// Reset: rst_n synchronous; clears counters, queue pointers and valids, loads config defaults.
// ----------------------------------------------------------------------------
// bayer_raw10_demosaic_to_nv12_unit
// RAW10 GRBG Bayer byte stream in, NV12 tiles (four luma, one Cb/Cr) out.
// Line stores are not cleared and read as undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_raw10_demosaic_to_nv12_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [12:0]     cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire bdn_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output bdn_pkg::out_t        out_data
);
  import bdn_pkg::*;

  cfg_t             cfg_r;
  logic             q_push, q_pop;
  tile_t            q_in, q_head;
  logic [Q_CW-1:0]  q_level;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_stride_bytes <= 13'd5104;
      cfg_r.crop_left        <= 12'd118;
      cfg_r.crop_top         <= 12'd322;
      cfg_r.out_width        <= 12'd3840;
      cfg_r.out_height       <= 12'd2160;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_STRIDE: cfg_r.row_stride_bytes <= cfg_wdata;
        CFG_CROP_LEFT:  cfg_r.crop_left        <= cfg_wdata[11:0];
        CFG_CROP_TOP:   cfg_r.crop_top         <= cfg_wdata[11:0];
        CFG_OUT_WIDTH:  cfg_r.out_width        <= cfg_wdata[11:0];
        CFG_OUT_HEIGHT: cfg_r.out_height       <= cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  bdn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_level  (q_level),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bdn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .level     (q_level)
  );

  bdn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_level   (q_level),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- sv/bdn_front.sv -----
// ----------------------------------------------------------------------------
// bdn_front
// Unpacks RAW10 bytes, tracks the source position, keeps three rotating line
// stores and gathers the 4x4 neighborhood of each finished tile.
// ----------------------------------------------------------------------------
`default_nettype none

module bdn_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bdn_pkg::cfg_t       cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bdn_pkg::in_t        in_data,
  input  wire logic [bdn_pkg::Q_CW-1:0] q_level,
  output logic                     q_push,
  output bdn_pkg::tile_t           q_data
);
  import bdn_pkg::*;

  // Position counters
  logic [12:0] bir_r, bir_nxt;
  logic [2:0]  gp_r, gp_nxt;
  logic [12:0] pc_r, pc_nxt;
  logic [11:0] sr_r, sr_nxt;
  logic [1:0]  slot_r, slot_nxt;

  logic        acc, kept;
  logic [12:0] bir_e, pc_e, bir_inc;
  logic [2:0]  gp_e;
  logic [11:0] sr_e;
  logic [1:0]  slot_e;
  logic [13:0] pc_p1;
  logic [LINE_AW-1:0] addr_a, addr_b;

  logic signed [14:0] ox, oy, ow_s, oh_s;
  logic        tile;

  // Window stage registers
  logic        w_v_r;
  logic [1:0]  w_slot_r;
  logic        w_col0_r, w_va_r, w_vb_r, w_top_r, w_tile_r, w_done_r;
  logic [7:0]  w_byte_r;
  logic [10:0] w_col_r, w_row_r;

  logic [7:0]  rda [NUM_SLOTS];
  logic [7:0]  rdb [NUM_SLOTS];

  // Hold last reads of each row so the window slides one column a step
  logic [7:0]  eh1_r, eh2_r, ph1_r, ph2_r, qh1_r, qh2_r, ev_r;

  // Hold input while the queue cannot take what is already in flight
  assign in_stall = ({1'b0, q_level} + {{Q_CW{1'b0}}, w_v_r}) >= (Q_CW+1)'(Q_DEPTH);
  assign acc      = in_valid && !in_stall;

  // Restart all counters on frame start before using this byte
  always_comb begin
    bir_e  = in_data.frame_start ? 13'd0 : bir_r;
    gp_e   = in_data.frame_start ? 3'd0  : gp_r;
    pc_e   = in_data.frame_start ? 13'd0 : pc_r;
    sr_e   = in_data.frame_start ? 12'd0 : sr_r;
    slot_e = in_data.frame_start ? 2'd0  : slot_r;
    kept   = gp_e < GROUP_LSB_PHASE;
    pc_p1  = {1'b0, pc_e} + 14'd1;
    addr_a = pc_e[LINE_AW-1:0];
    addr_b = pc_p1[LINE_AW-1:0];
  end

  // Advance counters and start a new row when the stride is reached
  always_comb begin
    bir_inc  = bir_e + 13'd1;
    gp_nxt   = (gp_e >= GROUP_LSB_PHASE) ? 3'd0 : gp_e + 3'd1;
    pc_nxt   = kept ? pc_e + 13'd1 : pc_e;
    bir_nxt  = bir_inc;
    sr_nxt   = sr_e;
    slot_nxt = slot_e;
    if (bir_inc >= cfg.row_stride_bytes) begin
      bir_nxt  = 13'd0;
      gp_nxt   = 3'd0;
      pc_nxt   = 13'd0;
      sr_nxt   = sr_e + 12'd1;
      slot_nxt = (slot_e == 2'd2) ? 2'd0 : slot_e + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r  <= '0;
      gp_r   <= '0;
      pc_r   <= '0;
      sr_r   <= '0;
      slot_r <= '0;
    end else if (acc) begin
      bir_r  <= bir_nxt;
      gp_r   <= gp_nxt;
      pc_r   <= pc_nxt;
      sr_r   <= sr_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Classify: does this pixel complete a tile of the crop window
  always_comb begin
    ox   = $signed({2'b0, pc_e}) - 15'sd1 - $signed({3'b0, cfg.crop_left[11:1], 1'b0});
    oy   = $signed({3'b0, sr_e}) - 15'sd2 - $signed({3'b0, cfg.crop_top[11:1], 1'b0});
    ow_s = $signed({3'b0, cfg.out_width[11:1], 1'b0});
    oh_s = $signed({3'b0, cfg.out_height[11:1], 1'b0});
    tile = !ox[14] && !ox[0] && (ox < ow_s) && !oy[14] && !oy[0] && (oy < oh_s);
  end

  // Line stores: write the current slot, read columns c and c+1 of every slot
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    logic [7:0] line_r [LINE_W];
    logic [7:0] a_r, b_r;
    always_ff @(posedge clk) begin
      if (acc && kept) begin
        if (slot_e == 2'(g) && !pc_e[12]) begin
          line_r[addr_a] <= in_data.data_byte;
        end
        a_r <= line_r[addr_a];
        b_r <= line_r[addr_b];
      end
    end
    assign rda[g] = a_r;
    assign rdb[g] = b_r;
  end

  // Carry the pixel's context into the window stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
    end else begin
      w_v_r <= acc && kept;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && kept) begin
      w_slot_r <= slot_e;
      w_col0_r <= (pc_e == 13'd0);
      w_va_r   <= !pc_e[12];
      w_vb_r   <= (pc_p1[13:12] == 2'b00);
      w_top_r  <= sr_e >= 12'd3;
      w_byte_r <= in_data.data_byte;
      w_tile_r <= tile;
      w_col_r  <= ox[11:1];
      w_row_r  <= oy[11:1];
      w_done_r <= (ox == ow_s - 15'sd2) && (oy == oh_s - 15'sd2);
    end
  end

  // Window stage: pick slots by role and slide the neighborhood
  logic [1:0] se, sp;
  logic [7:0] e1, e2, e0, em, p1, p2, p0, pm, m0r, m1r, m2r, q0, qm;

  always_comb begin
    se  = (w_slot_r == 2'd2) ? 2'd0 : w_slot_r + 2'd1;
    sp  = (w_slot_r == 2'd0) ? 2'd2 : w_slot_r - 2'd1;
    e1  = w_va_r ? rda[se] : 8'd0;
    e2  = w_vb_r ? rdb[se] : 8'd0;
    p1  = w_va_r ? rda[sp] : 8'd0;
    p2  = w_vb_r ? rdb[sp] : 8'd0;
    m1r = w_va_r ? rda[w_slot_r] : 8'd0;
    m2r = w_vb_r ? rdb[w_slot_r] : 8'd0;
    e0  = w_col0_r ? 8'd0 : eh1_r;
    em  = w_col0_r ? 8'd0 : eh2_r;
    p0  = w_col0_r ? 8'd0 : ph1_r;
    pm  = w_col0_r ? 8'd0 : ph2_r;
    m0r = w_col0_r ? 8'd0 : ev_r;
    q0  = w_col0_r ? 8'd0 : qh1_r;
    qm  = w_col0_r ? 8'd0 : qh2_r;
  end

  // Columns past the line store read back as zero, the current row included
  always_ff @(posedge clk) begin
    if (w_v_r) begin
      eh1_r <= e1;
      eh2_r <= e0;
      ph1_r <= p1;
      ph2_r <= p0;
      qh1_r <= w_va_r ? w_byte_r : 8'd0;
      qh2_r <= q0;
      ev_r  <= m1r;
    end
  end

  // Push completed tiles
  always_comb begin
    q_push            = w_v_r && w_tile_r;
    q_data.em         = em;
    q_data.e0         = e0;
    q_data.e1         = e1;
    q_data.e2         = e2;
    q_data.pm         = pm;
    q_data.p0         = p0;
    q_data.p1         = p1;
    q_data.p2         = p2;
    q_data.m0         = w_top_r ? m0r : 8'd0;
    q_data.m1         = w_top_r ? m1r : 8'd0;
    q_data.m2         = w_top_r ? m2r : 8'd0;
    q_data.qm         = qm;
    q_data.q0         = q0;
    q_data.q1         = w_byte_r;
    q_data.tile_col   = w_col_r;
    q_data.tile_row   = w_row_r;
    q_data.frame_done = w_done_r;
  end

endmodule

`default_nettype wire

// ----- sv/bdn_queue.sv -----
// ----------------------------------------------------------------------------
// bdn_queue
// Short queue of tile neighborhoods between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdn_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire bdn_pkg::tile_t            push_data,
  input  wire logic                      pop,
  output bdn_pkg::tile_t                 head,
  output logic [bdn_pkg::Q_CW-1:0]       level
);
  import bdn_pkg::*;

  tile_t            ent_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, rp_r;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;

  assign head  = ent_r[rp_r];
  assign level = cnt_r;

  // Track occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + Q_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + Q_AW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bdn_back.sv -----
// ----------------------------------------------------------------------------
// bdn_back
// Bilinear RGB at the four tile sites, then BT.601 luma and averaged chroma,
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdn_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bdn_pkg::tile_t      head,
  input  wire logic [bdn_pkg::Q_CW-1:0] q_level,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bdn_pkg::out_t            out_data
);
  import bdn_pkg::*;

  logic adv;
  logic s1_v_r, out_v_r;

  logic [7:0] r00_r, g00_r, b00_r, r01_r, g01_r, b01_r;
  logic [7:0] r10_r, g10_r, b10_r, r11_r, g11_r, b11_r;
  logic [7:0] rr_r, gg_r, bb_r;
  logic [10:0] col_r, row_r;
  logic        done_r;

  logic [7:0] r00, g00, b00, r01, g01, b01, r10, g10, b10, r11, g11, b11;
  logic [17:0] cb_v, cr_v;
  out_t       res, out_r;

  // Move the whole pipe when the output register frees up
  assign adv = !out_v_r || !out_stall;
  assign pop = adv && (q_level != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= pop;
      out_v_r <= s1_v_r;
    end
  end

  // Interpolate the four sites
  always_comb begin
    r00 = avg2(head.em, head.e1);
    g00 = head.e0;
    b00 = avg2(head.m0, head.p0);
    r01 = head.e1;
    g01 = avg4(head.e0, head.e2, head.m1, head.p1);
    b01 = avg4(head.m0, head.m2, head.p0, head.p2);
    r10 = avg4(head.em, head.e1, head.qm, head.q1);
    g10 = avg4(head.pm, head.p1, head.e0, head.q0);
    b10 = head.p0;
    r11 = avg2(head.e1, head.q1);
    g11 = head.p1;
    b11 = avg2(head.p0, head.p2);
  end

  always_ff @(posedge clk) begin
    if (adv && pop) begin
      r00_r  <= r00;
      g00_r  <= g00;
      b00_r  <= b00;
      r01_r  <= r01;
      g01_r  <= g01;
      b01_r  <= b01;
      r10_r  <= r10;
      g10_r  <= g10;
      b10_r  <= b10;
      r11_r  <= r11;
      g11_r  <= g11;
      b11_r  <= b11;
      rr_r   <= avg4(r00, r01, r10, r11);
      gg_r   <= avg4(g00, g01, g10, g11);
      bb_r   <= avg4(b00, b01, b10, b11);
      col_r  <= head.tile_col;
      row_r  <= head.tile_row;
      done_r <= head.frame_done;
    end
  end

  // Convert to luma and chroma
  always_comb begin
    cb_v = {10'd0, bb_r} * C_HALF + C_HALF
         - {10'd0, rr_r} * CB_R - {10'd0, gg_r} * CB_G;
    cr_v = {10'd0, rr_r} * C_HALF + C_HALF
         - {10'd0, gg_r} * CR_G - {10'd0, bb_r} * CR_B;
    res.tile_col          = col_r;
    res.tile_row          = row_r;
    res.luma_top_left     = luma(r00_r, g00_r, b00_r);
    res.luma_top_right    = luma(r01_r, g01_r, b01_r);
    res.luma_bottom_left  = luma(r10_r, g10_r, b10_r);
    res.luma_bottom_right = luma(r11_r, g11_r, b11_r);
    res.chroma_blue       = chroma_clip(cb_v);
    res.chroma_red        = chroma_clip(cr_v);
    res.frame_done        = done_r;
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
